[rtl/rms_edf_task_scheduler_core_assert.svh]
// assertion macros for the task scheduler core
`ifndef RMS_EDF_TASK_SCHEDULER_CORE_ASSERT_SVH
`define RMS_EDF_TASK_SCHEDULER_CORE_ASSERT_SVH

// property a must hold on every edge outside reset
`define RTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the next edge
`define RTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rts_pkg.sv]
// ---------------------------------------------------------------------------
// rts_pkg
// types and constants shared by the task scheduler core
// ---------------------------------------------------------------------------
package rts_pkg;

  localparam int MaxTasks  = 16;
  localparam int TimeWidth = 16;
  localparam int SlotW     = 4;
  localparam int ClockW    = 32;
  localparam int TaskW     = 3 * TimeWidth + 1;
  // dividend of the release modulo: clock plus offset
  localparam int DivW      = ClockW + 1;
  localparam int PerW      = TimeWidth + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PLAN  = 1'b1;
  localparam logic MODE_RMS = 1'b0;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_HYPER = 2'd1;

  typedef struct packed {
    logic [0:0]           opcode;
    logic [SlotW-1:0]     slot_index;
    logic [TimeWidth-1:0] period_in;
    logic [TimeWidth-1:0] budget_in;
    logic [TimeWidth-1:0] offset_in;
    logic [0:0]           active_in;
  } in_word_t;

  typedef struct packed {
    logic [0:0]           status;
    logic [0:0]           turn_valid;
    logic [SlotW-1:0]     turn_slot;
    logic [TimeWidth-1:0] run_cycles;
    logic [ClockW-1:0]    cycle_now;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_WRAP, ST_REL_RD, ST_REL_DIV, ST_REL_WB,
    ST_SEL_RD, ST_SEL_DIV, ST_SEL_ACC, ST_CHG_RD, ST_CHG_WB, ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DivW-1:0]      dividend;
    logic [PerW-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [PerW-1:0]      rem;
  } div_rsp_t;

endpackage

[rtl/rts_stream_if.sv]
// ---------------------------------------------------------------------------
// rts_stream_if
// valid/ready channel carrying one packed word
// ---------------------------------------------------------------------------
interface rts_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rts_ram.sv]
// ---------------------------------------------------------------------------
// rts_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module rts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/rts_divider.sv]
// ---------------------------------------------------------------------------
// rts_divider
// restoring remainder unit, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rts_divider (
  input  logic                clk,
  input  logic                rst,
  input  rts_pkg::div_req_t   req,
  output rts_pkg::div_rsp_t   rsp
);
  import rts_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo;
  logic [PerW:0]   rem;
  logic [PerW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [PerW:0]   trial;

  always_comb begin
    trial = {rem[PerW-1:0], quo[DivW-1]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DivW);
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        quo <= {quo[DivW-2:0], 1'b0};
        if (!trial[PerW]) begin
          rem <= trial;
        end else begin
          rem <= {rem[PerW-1:0], quo[DivW-1]};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem[PerW-1:0];
endmodule

[rtl/rms_edf_task_scheduler_core.sv]
// write item: the slot is written in ST_WRITE and the result registered in ST_OUT
// plan item: a release pass and a select pass over the slots, then ST_CHG_RD,
// ST_CHG_WB and ST_OUT; an overload ends the release pass early; an inactive slot
// skips the 33-step remainder unit, which is shared by both passes over the slots
// the core takes one item at a time; the next is taken once the result register is free
// rst clears the active, energy-valid and clock state at once; no sweep
// ---------------------------------------------------------------------------
// rms_edf_task_scheduler_core
// periodic task scheduler, rate monotonic or earliest deadline first
// ---------------------------------------------------------------------------
module rms_edf_task_scheduler_core (
  input  logic                    clk,
  input  logic                    rst,
  rts_stream_if.sink              in_ch,
  rts_stream_if.source            out_ch,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:2]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rts_pkg::*;

  logic                 sched_mode;
  logic [ClockW-1:0]    hyperperiod;
  logic [ClockW-1:0]    sched_clock;
  state_t               state, state_next;
  in_word_t             item;
  logic [SlotW-1:0]     idx;
  logic [MaxTasks-1:0]  active;
  logic [MaxTasks-1:0]  env;        // energy entry written since reset
  logic                 over;
  logic                 found, have_min;
  logic [SlotW-1:0]     pick;
  logic [PerW-1:0]      best_d, min_d, cur_d;
  logic [TimeWidth-1:0] pick_e;
  out_word_t            res;
  logic                 res_valid;

  // task ram: period, budget, offset, spare; energy in its own ram
  logic                 t_we, e_we;
  logic [SlotW-1:0]     t_wa, e_wa, t_ra, e_ra;
  logic [TaskW-1:0]     t_wd, t_rd;
  logic [TimeWidth-1:0] e_wd, e_rd, energy;
  logic [TimeWidth-1:0] tp, tb, to;
  logic [PerW-1:0]      eff_p;
  div_req_t             dreq;
  div_rsp_t             drsp;

  rts_ram #(.Width(TaskW), .Depth(MaxTasks)) u_task_ram (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  rts_ram #(.Width(TimeWidth), .Depth(MaxTasks)) u_energy_ram (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );
  rts_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign tp     = t_rd[TaskW-1 -: TimeWidth];
  assign tb     = t_rd[TaskW-1-TimeWidth -: TimeWidth];
  assign to     = t_rd[TimeWidth:1];
  assign energy = env[idx] ? e_rd : '0;
  assign eff_p  = (tp == '0) ? {1'b1, {TimeWidth{1'b0}}} : {1'b0, tp};
  assign cur_d  = eff_p - drsp.rem;
  assign t_ra   = idx;
  assign e_ra   = idx;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_MODE[0]: prdata = {31'b0, sched_mode};
      default:     prdata = hyperperiod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode  <= MODE_RMS;
      hyperperiod <= 32'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HYPER[0]) begin
        hyperperiod <= pwdata;
      end else begin
        sched_mode <= pwdata[0];
      end
    end
  end

  assign in_ch.ready  = (state == ST_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  always_comb begin
    state_next = state;
    dreq       = '0;
    dreq.dividend = {1'b0, sched_clock} + {{(DivW-TimeWidth){1'b0}}, to};
    dreq.divisor  = eff_p;
    t_we = 1'b0;
    t_wa = item.slot_index;
    t_wd = {item.period_in, item.budget_in, item.offset_in, 1'b0};
    e_we = 1'b0;
    e_wa = idx;
    e_wd = '0;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_next = (in_ch.data.opcode == OP_WRITE) ? ST_WRITE : ST_WRAP;
        end
      end
      ST_WRITE: begin
        t_we = 1'b1;
        e_we = 1'b1;
        e_wa = item.slot_index;
        state_next = ST_OUT;
      end
      ST_WRAP:   state_next = ST_REL_RD;
      ST_REL_RD: begin
        if (active[idx]) begin
          state_next = ST_REL_DIV;
        end else if (idx == SlotW'(MaxTasks-1)) begin
          state_next = ST_SEL_RD;
        end
      end
      // slot words come from the registered ram read in ST_REL_RD, so the divide starts here
      ST_REL_DIV: begin
        if (drsp.done) begin
          state_next = ST_REL_WB;
        end else if (!drsp.busy) begin
          dreq.start = 1'b1;
        end
      end
      ST_REL_WB: begin
        if (drsp.rem == '0) begin
          if (energy != '0) begin
            state_next = ST_OUT;
          end else begin
            e_we = 1'b1;
            e_wd = tb;
          end
        end
        if (!(drsp.rem == '0 && energy != '0)) begin
          state_next = (idx == SlotW'(MaxTasks-1)) ? ST_SEL_RD : ST_REL_RD;
        end
      end
      ST_SEL_RD: begin
        if (active[idx]) begin
          state_next = ST_SEL_DIV;
        end else begin
          state_next = ST_SEL_ACC;
        end
      end
      ST_SEL_DIV: begin
        if (drsp.done) begin
          state_next = ST_SEL_ACC;
        end else if (!drsp.busy) begin
          dreq.start = 1'b1;
        end
      end
      ST_SEL_ACC: state_next = (idx == SlotW'(MaxTasks-1)) ? ST_CHG_RD : ST_SEL_RD;
      ST_CHG_RD:  state_next = ST_CHG_WB;
      ST_CHG_WB: begin
        if (found) begin
          e_we = 1'b1;
          e_wd = pick_e - res.run_cycles;
        end
        state_next = ST_OUT;
      end
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sched_clock <= '0;
      active      <= '0;
      env         <= '0;
      res_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
      if (e_we) begin
        env[e_wa] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item     <= in_ch.data;
            idx      <= '0;
            over     <= 1'b0;
            found    <= 1'b0;
            have_min <= 1'b0;
            pick     <= '0;
            res      <= '0;
          end
        end
        ST_WRITE: active[item.slot_index] <= item.active_in[0];
        ST_WRAP: begin
          if (sched_clock == hyperperiod) begin
            sched_clock <= '0;
          end
        end
        ST_REL_RD: begin
          if (!active[idx]) begin
            idx <= idx + 1'b1;
          end
        end
        ST_REL_WB: begin
          if (drsp.rem == '0 && energy != '0) begin
            over <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        ST_SEL_ACC: begin
          if (active[idx] && (!have_min || cur_d < min_d)) begin
            min_d    <= cur_d;
            have_min <= 1'b1;
          end
          if (energy != '0) begin
            if (sched_mode == MODE_RMS) begin
              if (!found) begin
                found  <= 1'b1;
                pick   <= idx;
                pick_e <= energy;
              end
            end else if (active[idx] && (!found || cur_d < best_d)) begin
              found  <= 1'b1;
              pick   <= idx;
              best_d <= cur_d;
              pick_e <= energy;
            end
          end
          idx <= idx + 1'b1;
        end
        ST_CHG_RD: begin
          idx <= pick;
          if (found) begin
            res.turn_valid <= 1'b1;
            res.turn_slot  <= pick;
            res.run_cycles <= (have_min && min_d < {1'b0, pick_e}) ?
                              min_d[TimeWidth-1:0] : pick_e;
          end
        end
        ST_CHG_WB: begin
          sched_clock <= found ? sched_clock + ClockW'(res.run_cycles) : sched_clock + 1'b1;
        end
        ST_OUT: begin
          res.status    <= over;
          res.cycle_now <= sched_clock;
          res_valid     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `include "rms_edf_task_scheduler_core_assert.svh"

  `RTS_ASSERT(a_no_take_while_full, !(res_valid && in_ch.ready), "input taken over full result")
  `RTS_ASSERT_NEXT(a_out_after_write, state == ST_WRITE, state == ST_OUT, "write did not finish")
  `RTS_ASSERT(a_over_no_grant, !(out_ch.valid && res.status == 1'b1 && res.turn_valid == 1'b1), "grant on overload")

endmodule

[test/rms_edf_task_scheduler_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rms_edf_task_scheduler_core_test
// drives slot writes and plan steps through the scheduler core, predicts
// every result word in a scoreboard class and checks it field by field,
// under several modes, hyperperiods and idle patterns on both channels
// ---------------------------------------------------------------------------
module rms_edf_task_scheduler_core_test;
  import rts_pkg::*;

  localparam int InBits = $bits(in_word_t);

  class plan_tracker;
    logic [TimeWidth-1:0] period_q [MaxTasks];
    logic [TimeWidth-1:0] offset_q [MaxTasks];
    logic [TimeWidth-1:0] budget_q [MaxTasks];
    logic [TimeWidth-1:0] energy_q [MaxTasks];
    logic                 active_q [MaxTasks];
    logic [ClockW-1:0]    clock_q;
    logic                 mode_q;
    logic [ClockW-1:0]    hyper_q;
    out_word_t            expected_turns [$];
    int mismatches, writes, plans, overloads, grants, wraps;

    function void clear();
      for (int i = 0; i < MaxTasks; i++) begin
        energy_q[i] = '0;
        active_q[i] = 1'b0;
      end
      clock_q = '0;
      mode_q  = MODE_RMS;
      hyper_q = 32'd1;
    endfunction

    // (clock + offset) mod period, zero period standing for 2^TimeWidth
    function longint unsigned phase_of(int i, output longint unsigned per);
      per = (period_q[i] == 0) ? (64'd1 << TimeWidth) : longint'(period_q[i]);
      return (longint'(clock_q) + longint'(offset_q[i])) % per;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      logic over, found, have_min;
      int pick;
      longint unsigned per, ph, d, best_d, min_d, e, run;
      r = '0;
      over = 0; found = 0; have_min = 0; pick = 0; best_d = 0; min_d = 0;
      if (w.opcode == OP_WRITE) begin
        writes++;
        period_q[w.slot_index] = w.period_in;
        budget_q[w.slot_index] = w.budget_in;
        offset_q[w.slot_index] = w.offset_in;
        active_q[w.slot_index] = w.active_in;
        energy_q[w.slot_index] = '0;
      end else begin
        plans++;
        if (clock_q == hyper_q) begin
          clock_q = '0;
          wraps++;
        end
        for (int i = 0; i < MaxTasks && !over; i++) begin
          if (active_q[i]) begin
            ph = phase_of(i, per);
            if (ph == 0) begin
              if (energy_q[i] != 0) over = 1;
              else energy_q[i] = budget_q[i];
            end
          end
        end
        if (over) begin
          r.status = 1'b1;
          overloads++;
        end else begin
          for (int i = 0; i < MaxTasks; i++) begin
            d = 0;
            if (active_q[i]) begin
              ph = phase_of(i, per);
              d = per - ph;
              if (!have_min || d < min_d) begin
                min_d = d;
                have_min = 1;
              end
            end
            if (energy_q[i] != 0) begin
              if (mode_q == MODE_RMS) begin
                if (!found) begin
                  found = 1;
                  pick = i;
                end
              end else if (active_q[i] && (!found || d < best_d)) begin
                found = 1;
                pick = i;
                best_d = d;
              end
            end
          end
          if (found) begin
            e = 64'(energy_q[pick]);
            run = (have_min && min_d < e) ? min_d : e;
            energy_q[pick] = TimeWidth'(e - run);
            clock_q = clock_q + run[ClockW-1:0];
            r.turn_valid = 1'b1;
            r.turn_slot = pick[SlotW-1:0];
            r.run_cycles = run[TimeWidth-1:0];
            grants++;
          end else begin
            clock_q = clock_q + 1;
          end
        end
      end
      r.cycle_now = clock_q;
      expected_turns.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_turns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = expected_turns.pop_front();
      if (got.status !== want.status || got.turn_valid !== want.turn_valid ||
          got.turn_slot !== want.turn_slot || got.run_cycles !== want.run_cycles ||
          got.cycle_now !== want.cycle_now) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st=%0d v=%0d slot=%0d run=%0d clk=%0d, got st=%0d v=%0d slot=%0d run=%0d clk=%0d",
                   want.status, want.turn_valid, want.turn_slot, want.run_cycles,
                   want.cycle_now, got.status, got.turn_valid, got.turn_slot,
                   got.run_cycles, got.cycle_now);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  rts_stream_if #(.word_t(in_word_t))  in_ch ();
  rts_stream_if #(.word_t(out_word_t)) out_ch ();

  rms_edf_task_scheduler_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  plan_tracker sb = new();
  int idle_pct, stall_pct, words_in;
  logic hold_req, hold_on;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.note_word(in_ch.data);
      words_in++;
    end
    if (!rst && out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
  end

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !hold_on && ($urandom_range(99) >= stall_pct);
    end
  end

  // long hold-off so the core backs up and stalls its input
  initial begin
    hold_on = 1'b0;
    wait (hold_req);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (6000) @(negedge clk);
    hold_on = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = idx[0]; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_MODE) sb.mode_q = val[0];
    else sb.hyper_q = val;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic load_slot(input int s, input int per, input int bud, input int off,
                           input logic act);
    in_word_t w;
    w.opcode = OP_WRITE; w.slot_index = SlotW'(s); w.period_in = TimeWidth'(per);
    w.budget_in = TimeWidth'(bud); w.offset_in = TimeWidth'(off); w.active_in = act;
    send_word(w);
  endtask

  task automatic plan_step();
    in_word_t w;
    w = in_word_t'(InBits'({$urandom, $urandom}));
    w.opcode = OP_PLAN;
    send_word(w);
  endtask

  task automatic load_random_slot(input int s);
    int per, bud, off;
    per = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 60);
    bud = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
    off = ($urandom_range(1) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 30);
    load_slot(s, per, bud, off, $urandom_range(9) < 7);
  endtask

  // wait for every word to drain before touching the registers
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_turns.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] hyp;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    idle_pct = 20; stall_pct = 85; words_in = 0; hold_req = 1'b0;
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero period, overload, clock stepping over the wrap
    write_reg(REG_HYPER, 32'd20);
    load_slot(0, 5, 2, 0, 1'b1);
    load_slot(1, 0, 16'hFFFF, 16'hFFFF, 1'b1);
    load_slot(15, 16'hFFFF, 0, 0, 1'b0);
    repeat (6) plan_step();
    load_slot(2, 1, 3, 0, 1'b1);
    repeat (4) plan_step();
    drain();
    write_reg(REG_MODE, 32'd1);
    repeat (6) plan_step();

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: hyp = 32'd1;
        1: hyp = 32'hFFFF_FFFF;
        3: hyp = $urandom;
        default: hyp = $urandom_range(1, 400);
      endcase
      write_reg(REG_MODE, ph % 2);
      write_reg(REG_HYPER, hyp);
      for (int s = 0; s < MaxTasks; s++) load_random_slot(s);
      for (int n = 0; n < 190; n++) begin
        if (words_in > 1140) begin
          idle_pct = 0; stall_pct = 0;
          if (n == 20) hold_req = 1'b1;
        end else if (words_in > 570) begin
          idle_pct = 85; stall_pct = 20;
        end
        if ($urandom_range(9) == 0) load_random_slot($urandom_range(0, 15));
        else plan_step();
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_turns.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d slot writes and %0d plan steps in both modes", sb.writes, sb.plans);
    $display("%0d grants, %0d overloads, %0d clock wraps seen", sb.grants, sb.overloads,
             sb.wraps);
    if (sb.mismatches == 0 && sb.expected_turns.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
